// ===== hw/rtl/wma_pkg.sv =====
`default_nettype none
package wma_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int WINDOW_LENGTH_DEF = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/wma_ram.sv =====
`default_nettype none
module wma_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wma_div.sv =====
`default_nettype none
module wma_div #(
    parameter int NW = 19,
    parameter int DW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic      [NW-1:0] o_quotient
);

    localparam int CNT_W = (NW > 1) ? $clog2(NW) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NW-1:0]    r_q, n_q;
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_dsr, n_dsr;
    logic [DW:0]      trial;
    logic [DW:0]      diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    always_comb begin
        trial  = {r_rem, r_q[NW-1]};
        diff   = trial - {1'b0, r_dsr};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (r_busy) begin
            if (!diff[DW]) begin
                n_rem = diff[DW-1:0];
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = trial[DW-1:0];
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

// ===== hw/rtl/warmup_moving_average.sv =====
`default_nettype none
// Boxcar moving average of signed Q3.12 joint angles over the last WINDOW_LENGTH samples.
// Until the window fills, the average covers only the samples seen so far; o_window_full
// rises once WINDOW_LENGTH samples have arrived. The quotient truncates toward zero. Each
// request passes through the read, update, divide-start, divide and finish states after
// acceptance; the divide phase uses a restoring divider that retires one quotient bit per
// cycle. o_ready is low from acceptance until the result enters the output register. A finished
// result waits in the output register while the next request is accepted.
module warmup_moving_average #(
    parameter int WINDOW_LENGTH = wma_pkg::WINDOW_LENGTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [wma_pkg::SAMPLE_W-1:0] i_angle_sample,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [wma_pkg::SAMPLE_W-1:0] o_smoothed_angle,
    output logic                               o_window_full
);

    localparam int XW = wma_pkg::SAMPLE_W;
    localparam int SW = XW + $clog2(WINDOW_LENGTH);
    localparam int CW = $clog2(WINDOW_LENGTH + 1);
    localparam int AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    wma_pkg::t_state   r_state, n_state;

    logic [CW-1:0]        r_fill, n_fill;
    logic [AW-1:0]        r_wpos, n_wpos;
    logic signed [SW-1:0] r_sum, n_sum;
    logic signed [XW-1:0] r_sample, n_sample;
    logic                 r_out_valid, n_out_valid;
    logic signed [XW-1:0] r_out_angle, n_out_angle;
    logic                 r_out_full, n_out_full;
    logic                 r_neg, n_neg;
    logic [SW-1:0]        r_mag, n_mag;

    logic                 ram_we;
    logic [XW-1:0]        ram_rdata;
    logic signed [SW-1:0] old_ext;
    logic signed [SW-1:0] new_ext;
    logic                 full;
    logic [SW-1:0]        quotient;
    logic [SW-1:0]        signed_q;
    logic                 div_start;
    logic                 div_done;

    assign full    = (r_fill == CW'(WINDOW_LENGTH));
    assign old_ext = SW'($signed(ram_rdata));
    assign new_ext = SW'(r_sample);

    wma_ram #(
        .WIDTH(XW),
        .DEPTH(WINDOW_LENGTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wpos),
        .i_wdata(r_sample),
        .i_raddr(r_wpos),
        .o_rdata(ram_rdata)
    );

    wma_div #(
        .NW(SW),
        .DW(CW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_mag),
        .i_divisor (r_fill),
        .o_done    (div_done),
        .o_quotient(quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wma_pkg::ST_IDLE;
            r_fill      <= '0;
            r_wpos      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_wpos      <= n_wpos;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_sample    <= n_sample;
        r_out_angle <= n_out_angle;
        r_out_full  <= n_out_full;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_wpos      = r_wpos;
        n_sum       = r_sum;
        n_sample    = r_sample;
        n_out_valid = r_out_valid;
        n_out_angle = r_out_angle;
        n_out_full  = r_out_full;
        n_neg       = r_neg;
        n_mag       = r_mag;
        o_ready     = 1'b0;
        ram_we      = 1'b0;
        div_start   = 1'b0;
        signed_q    = r_neg ? (~quotient + 1'b1) : quotient;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            wma_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_sample = i_angle_sample;
                    n_state  = wma_pkg::ST_READ;
                end
            end
            wma_pkg::ST_READ: begin
                n_state = wma_pkg::ST_UPDATE;
            end
            wma_pkg::ST_UPDATE: begin
                ram_we = 1'b1;
                if (full) begin
                    n_sum = r_sum - old_ext + new_ext;
                end else begin
                    n_sum  = r_sum + new_ext;
                    n_fill = r_fill + 1'b1;
                end
                if (r_wpos == AW'(WINDOW_LENGTH - 1)) begin
                    n_wpos = '0;
                end else begin
                    n_wpos = r_wpos + 1'b1;
                end
                n_neg   = n_sum[SW-1];
                n_mag   = n_sum[SW-1] ? (~n_sum + 1'b1) : n_sum;
                n_state = wma_pkg::ST_DIV_START;
            end
            wma_pkg::ST_DIV_START: begin
                div_start = 1'b1;
                n_state   = wma_pkg::ST_DIV;
            end
            wma_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = wma_pkg::ST_FINISH;
                end
            end
            wma_pkg::ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_angle = signed_q[XW-1:0];
                    n_out_full  = full;
                    n_state     = wma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wma_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_smoothed_angle = r_out_angle;
    assign o_window_full    = r_out_full;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_LENGTH))
        else $error("fill count beyond window length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wma_pkg::ST_UPDATE) |=> (r_fill != '0))
        else $error("divisor zero after update");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == wma_pkg::ST_DIV))
        else $error("divider done outside divide phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while busy");

endmodule
`default_nettype wire
